// ===== design/spq_pkg.sv =====
// Shared request, status and state codes of the sorted priority queue.
`default_nettype none

package spq_pkg;

   // request kinds
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_PEEK   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HEAD
   } state_type;

endpackage

`default_nettype wire

// ===== design/sorted_priority_queue_unit.sv =====
// Sorted priority queue built around one circular entry memory with a registered read.
//
// Entries live in a circular buffer: a head pointer marks the next entry to serve, so a
// remove only advances the pointer. An insert walks from the head toward the tail through
// the memory's read port, one entry per cycle. It drops the new entry into the first slot
// whose entry must follow the new key, then ripples every later entry one slot back. With
// n entries held: an insert into an empty or a full queue, request code three, and a
// remove or peek on an empty queue never raise busy; an insert into a queue that is neither
// empty nor full keeps busy high while it walks all n entries and then writes the final one;
// a remove or peek on a non-empty queue keeps busy high while the head entry is taken. Every
// request gets exactly one result, shown on the rsp_ ports for one cycle with rsp_valid high,
// in the cycle after the request's last cycle of work. The receiver cannot stall: results
// must be taken when rsp_valid is high. csr_wdata picks the order (0 smallest key first,
// 1 largest key first); write it only while busy is low and no result is pending. Entries
// already held keep their places when the order changes.
`default_nettype none

module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int KEY_WIDTH  = 32,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [1:0]                           req_func,
   input  wire logic [KEY_WIDTH-1:0]                 req_item_key,
   input  wire logic [DATA_WIDTH-1:0]                req_item_payload,
   output logic                                      rsp_valid,
   output logic [1:0]                                rsp_status,
   output logic [KEY_WIDTH-1:0]                      rsp_head_key,
   output logic [DATA_WIDTH-1:0]                     rsp_head_payload,
   output logic [$clog2(CAPACITY+1)-1:0]             rsp_entry_count,
   input  wire logic                                 csr_we,
   input  wire logic                                 csr_wdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = $clog2(2 * CAPACITY);
   localparam int EW = KEY_WIDTH + DATA_WIDTH;
   localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      r = (p == LAST_IDX) ? '0 : p + AW'(1);
      return r;
   endfunction

   // control state
   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              desc_ff, desc_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic              found_ff, found_in;
   logic [CW-1:0]     remain_ff, remain_in;
   logic [1:0]        func_ff, func_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [DATA_WIDTH-1:0] pay_ff, pay_in;

   // result registers
   status_type            rsp_status_ff, rsp_status_in;
   logic [KEY_WIDTH-1:0]  rsp_key_ff, rsp_key_in;
   logic [DATA_WIDTH-1:0] rsp_pay_ff, rsp_pay_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;

   // entry memory
   logic [EW-1:0]     entry_mem [CAPACITY];
   logic [EW-1:0]     rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [EW-1:0]     mem_wdata;
   logic [AW-1:0]     mem_raddr;

   logic [SW-1:0]     slot_sum;
   logic [AW-1:0]     slot_ins;
   logic [KEY_WIDTH-1:0]  held_key;
   logic              stays_ahead;

   // physical slot just past the tail
   assign slot_sum = SW'(head_ff) + SW'(cnt_ff);
   assign slot_ins = (slot_sum >= SW'(CAPACITY)) ? AW'(slot_sum - SW'(CAPACITY))
                                                 : AW'(slot_sum);

   assign held_key    = rd_data_ff[EW-1:DATA_WIDTH];
   assign stays_ahead = desc_ff ? (held_key >= key_ff) : (held_key <= key_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      desc_in       = csr_we ? csr_wdata : desc_ff;
      rd_ptr_in     = rd_ptr_ff;
      found_in      = found_ff;
      remain_in     = remain_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_key_in    = '0;
      rsp_pay_in    = '0;
      rsp_count_in  = cnt_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_ptr_ff;
      mem_wdata     = {key_ff, pay_ff};
      mem_raddr     = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = req_func;
               key_in  = req_item_key;
               pay_in  = req_item_payload;
               case (req_func)
                  FUNC_INSERT: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else if (cnt_ff == '0) begin
                        mem_we       = 1'b1;
                        mem_waddr    = slot_ins;
                        mem_wdata    = {req_item_key, req_item_payload};
                        cnt_in       = CW'(1);
                        rsp_valid_in = 1'b1;
                        rsp_count_in = CW'(1);
                     end else begin
                        rd_ptr_in = head_ff;
                        found_in  = 1'b0;
                        remain_in = cnt_ff;
                        state_in  = ST_SCAN;
                     end
                  end
                  FUNC_REMOVE, FUNC_PEEK: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_HEAD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // rd_data_ff holds the entry at rd_ptr_ff; key_ff/pay_ff carry the entry to place
            if (remain_ff == '0) begin
               mem_we       = 1'b1;
               mem_waddr    = rd_ptr_ff;
               mem_wdata    = {key_ff, pay_ff};
               cnt_in       = cnt_ff + CW'(1);
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff + CW'(1);
               state_in     = ST_IDLE;
            end else begin
               rd_ptr_in = ptr_inc(rd_ptr_ff);
               mem_raddr = ptr_inc(rd_ptr_ff);
               remain_in = remain_ff - CW'(1);
               // once placed, every later entry moves back one slot
               if (found_ff || !stays_ahead) begin
                  mem_we    = 1'b1;
                  mem_waddr = rd_ptr_ff;
                  mem_wdata = {key_ff, pay_ff};
                  key_in    = held_key;
                  pay_in    = rd_data_ff[DATA_WIDTH-1:0];
                  found_in  = 1'b1;
               end
            end
         end

         ST_HEAD: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = rd_data_ff[EW-1:DATA_WIDTH];
            rsp_pay_in   = rd_data_ff[DATA_WIDTH-1:0];
            if (func_ff == FUNC_REMOVE) begin
               head_in      = ptr_inc(head_ff);
               cnt_in       = cnt_ff - CW'(1);
               rsp_count_in = cnt_ff - CW'(1);
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         desc_ff      <= desc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      found_ff      <= found_in;
      remain_ff     <= remain_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[mem_raddr];
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_head_key     = rsp_key_ff;
   assign rsp_head_payload = rsp_pay_ff;
   assign rsp_entry_count  = rsp_count_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_scan_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> remain_ff <= cnt_ff)
      else $error("insert walk beyond held entries");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      start && !busy && cnt_ff == '0 && (req_func == FUNC_REMOVE || req_func == FUNC_PEEK)
      |=> rsp_valid && rsp_status == STATUS_EMPTY)
      else $error("empty queue not reported");

   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_INSERT && cnt_ff == CW'(CAPACITY)
      |=> rsp_valid && rsp_status == STATUS_FULL && cnt_ff == $past(cnt_ff))
      else $error("insert into full queue not refused");

endmodule

`default_nettype wire
